// ===== design/hwms_pkg.sv =====
// shared types and constants of the hamming window match scanner
// no dependencies; used by the cell, the top level and the checker
package hwms_pkg;

   localparam int CFG_W   = 11;
   localparam int IDX_W   = 10;
   localparam int BASE_W  = 8;
   localparam int POS_W   = 32;
   localparam int MATCH_W = 11;

   localparam logic [MATCH_W-1:0] COUNT_MAX = 11'd2047;

   typedef enum logic [1:0] {
      REQ_FWD     = 2'd0,
      REQ_REV     = 2'd1,
      REQ_GENOME  = 2'd2,
      REQ_RESTART = 2'd3
   } req_code_type;

   typedef enum logic {
      CSR_READ_LENGTH = 1'b0,
      CSR_MIN_MATCHES = 1'b1
   } csr_index_type;

   // broadcast controls from the sequencer to every cell
   typedef struct packed {
      logic shift;     // new genome base enters the ring
      logic rotate;    // plain ring rotation, used to realign the window
      logic start;     // launch a count token at the entry cell
      logic advance;   // tokens move one cell toward cell 0
      logic load_fwd;  // forward pattern write
      logic load_rev;  // reverse pattern write
   } ctl_type;

endpackage

// ===== design/hwms_cell.sv =====
// one cell of the scan chain: a pattern byte pair, one window byte and a count token
// depends on hwms_pkg
module hwms_cell #(
   parameter int MAX_READ_LEN = 1024,
   parameter int CELL_INDEX   = 0
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  hwms_pkg::ctl_type                    ctl,
   input  logic [$clog2(MAX_READ_LEN + 1)-1:0]  frame_len,
   input  logic [hwms_pkg::BASE_W-1:0]          base,
   input  logic [hwms_pkg::IDX_W-1:0]           load_index,
   input  logic [hwms_pkg::BASE_W-1:0]          up_window,
   input  logic                                 up_tok_valid,
   input  logic [$clog2(MAX_READ_LEN + 1)-1:0]  up_fwd_count,
   input  logic [$clog2(MAX_READ_LEN + 1)-1:0]  up_rev_count,
   output logic [hwms_pkg::BASE_W-1:0]          window,
   output logic                                 tok_valid,
   output logic [$clog2(MAX_READ_LEN + 1)-1:0]  fwd_count,
   output logic [$clog2(MAX_READ_LEN + 1)-1:0]  rev_count
);
   import hwms_pkg::*;

   localparam int CNT_W = $clog2(MAX_READ_LEN + 1);

   logic [BASE_W-1:0] fwd_pat_ff, fwd_pat_in;
   logic [BASE_W-1:0] rev_pat_ff, rev_pat_in;
   logic [BASE_W-1:0] win_ff, win_in;
   logic              tok_ff, tok_in;
   logic [CNT_W-1:0]  fcnt_ff, fcnt_in;
   logic [CNT_W-1:0]  rcnt_ff, rcnt_in;
   logic              is_entry, is_target, fwd_match, rev_match;

   assign is_entry  = (32'(frame_len) == 32'(CELL_INDEX + 1));
   assign is_target = (32'(load_index) == 32'(CELL_INDEX));
   assign fwd_match = (fwd_pat_ff == win_ff);
   assign rev_match = (rev_pat_ff == win_ff);

   always_comb begin
      fwd_pat_in = fwd_pat_ff;
      rev_pat_in = rev_pat_ff;
      win_in     = win_ff;
      tok_in     = tok_ff;
      fcnt_in    = fcnt_ff;
      rcnt_in    = rcnt_ff;
      if (ctl.load_fwd && is_target) begin
         fwd_pat_in = base;
      end
      if (ctl.load_rev && is_target) begin
         rev_pat_in = base;
      end
      if (ctl.shift) begin
         win_in = is_entry ? base : up_window;
      end else if (ctl.rotate) begin
         win_in = up_window;
      end
      if (ctl.start) begin
         tok_in  = is_entry;
         fcnt_in = CNT_W'(fwd_match);
         rcnt_in = CNT_W'(rev_match);
      end else if (ctl.advance) begin
         tok_in  = up_tok_valid;
         fcnt_in = up_fwd_count + CNT_W'(fwd_match);
         rcnt_in = up_rev_count + CNT_W'(rev_match);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
      fwd_pat_ff <= fwd_pat_in;
      rev_pat_ff <= rev_pat_in;
      win_ff     <= win_in;
      fcnt_ff    <= fcnt_in;
      rcnt_ff    <= rcnt_in;
   end

   assign window    = win_ff;
   assign tok_valid = tok_ff;
   assign fwd_count = fcnt_ff;
   assign rev_count = rcnt_ff;

endmodule

// ===== design/hamming_window_match_scan_top.sv =====
// top level of the hamming window match scanner: sequencer, counters and the cell chain
// depends on hwms_pkg and hwms_cell
//
// The block holds a forward and a reverse pattern, loaded one base per item, and scans a
// genome stream one base per item against both. It keeps the last MAX_READ_LEN genome
// bases in a ring of cells; every genome base that completes a window of read_length bases
// launches a count token that walks the chain from the entry cell down to cell 0, adding
// one match bit per strand in each cell. A genome base that completes a window first
// shifts the ring; the token is launched from the registered start flag and then walks
// as many cells as the window length, read_length after clamping, and no new request is
// taken until its result leaves cell 0. The finished result sits in an output register,
// so a stalled consumer holds only the next scan, not the next load or restart. After a
// write to read_length the ring rotates one cell per cycle while no scan is busy until
// it lines up with the new length, and req_ready stays low meanwhile. Pattern and window
// storage have no reset and no clearing pass.
module hamming_window_match_scan_top #(
   parameter int MAX_READ_LEN = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_type,
   input  logic [hwms_pkg::IDX_W-1:0]      req_pattern_index,
   input  logic [hwms_pkg::BASE_W-1:0]     req_base,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [hwms_pkg::POS_W-1:0]      rsp_window_start,
   output logic                            rsp_forward_hit,
   output logic                            rsp_reverse_hit,
   output logic [hwms_pkg::MATCH_W-1:0]    rsp_forward_matches,
   output logic [hwms_pkg::MATCH_W-1:0]    rsp_reverse_matches,
   // register write port
   input  logic                            csr_write_enable,
   input  logic                            csr_index,
   input  logic [hwms_pkg::CFG_W-1:0]      csr_write_data
);
   import hwms_pkg::*;

   // one width serves window lengths, fill level and match counts
   localparam int CNT_W = $clog2(MAX_READ_LEN + 1);

   // configuration
   logic [CFG_W-1:0]   read_length_ff, read_length_in;
   logic [CFG_W-1:0]   min_matches_ff, min_matches_in;
   // window length the ring is currently aligned to
   logic [CNT_W-1:0]   frame_len_ff, frame_len_in;
   // scan state
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [POS_W-1:0]   seen_ff, seen_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               busy_ff, busy_in;
   logic               start_ff, start_in;
   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]   rsp_start_ff, rsp_start_in;
   logic               rsp_fhit_ff, rsp_fhit_in;
   logic               rsp_rhit_ff, rsp_rhit_in;
   logic [MATCH_W-1:0] rsp_fcnt_ff, rsp_fcnt_in;
   logic [MATCH_W-1:0] rsp_rcnt_ff, rsp_rcnt_in;

   logic [CNT_W-1:0]   len_eff;
   logic [CNT_W-1:0]   fill_next;
   logic               aligned, accept, result_take, fwd_hit, rev_hit;
   ctl_type            cell_ctl;

   // chain wiring
   logic [BASE_W-1:0]  win     [MAX_READ_LEN];
   logic               tok_v   [MAX_READ_LEN];
   logic [CNT_W-1:0]   fcnt    [MAX_READ_LEN];
   logic [CNT_W-1:0]   rcnt    [MAX_READ_LEN];
   logic               up_tok_v[MAX_READ_LEN];
   logic [CNT_W-1:0]   up_fcnt [MAX_READ_LEN];
   logic [CNT_W-1:0]   up_rcnt [MAX_READ_LEN];

   // zero length acts as one, anything past the chain acts as the full chain
   always_comb begin
      if (read_length_ff == '0) begin
         len_eff = CNT_W'(1);
      end else if (32'(read_length_ff) > 32'(MAX_READ_LEN)) begin
         len_eff = CNT_W'(MAX_READ_LEN);
      end else begin
         len_eff = CNT_W'(read_length_ff);
      end
   end

   assign aligned   = (frame_len_ff == len_eff);
   assign req_ready = aligned && !busy_ff;
   assign accept    = req_valid && req_ready;
   assign fill_next = (32'(fill_ff) < 32'(MAX_READ_LEN)) ? fill_ff + CNT_W'(1) : fill_ff;

   // token sitting at cell 0 holds the finished counts
   assign result_take = tok_v[0] && (!rsp_valid_ff || rsp_ready);
   assign fwd_hit     = (32'(fcnt[0]) >= 32'(min_matches_ff));
   assign rev_hit     = (32'(rcnt[0]) >= 32'(min_matches_ff));

   always_comb begin
      read_length_in = read_length_ff;
      min_matches_in = min_matches_ff;
      frame_len_in   = frame_len_ff;
      fill_in        = fill_ff;
      seen_in        = seen_ff;
      pos_in         = pos_ff;
      busy_in        = busy_ff;
      start_in       = 1'b0;
      rsp_valid_in   = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_start_in   = rsp_start_ff;
      rsp_fhit_in    = rsp_fhit_ff;
      rsp_rhit_in    = rsp_rhit_ff;
      rsp_fcnt_in    = rsp_fcnt_ff;
      rsp_rcnt_in    = rsp_rcnt_ff;
      cell_ctl       = '0;

      // tokens hold only while cell 0 waits on a full output register
      cell_ctl.advance = !tok_v[0] || result_take;
      cell_ctl.start   = start_ff;

      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_READ_LENGTH: begin
               read_length_in = csr_write_data;
            end
            CSR_MIN_MATCHES: begin
               min_matches_in = csr_write_data;
            end
            default: begin
            end
         endcase
      end

      // realign: one rotation lowers the aligned length by one, wrapping 1 to full chain
      if (!aligned && !busy_ff) begin
         cell_ctl.rotate = 1'b1;
         frame_len_in    = (frame_len_ff == CNT_W'(1)) ? CNT_W'(MAX_READ_LEN)
                                                       : frame_len_ff - CNT_W'(1);
      end

      if (accept) begin
         case (req_code_type'(req_type))
            REQ_FWD: begin
               cell_ctl.load_fwd = 1'b1;
            end
            REQ_REV: begin
               cell_ctl.load_rev = 1'b1;
            end
            REQ_GENOME: begin
               cell_ctl.shift = 1'b1;
               fill_in        = fill_next;
               seen_in        = seen_ff + 32'd1;
               if (fill_next >= len_eff) begin
                  busy_in  = 1'b1;
                  start_in = 1'b1;
                  pos_in   = seen_ff - 32'(len_eff) + 32'd1;
               end
            end
            REQ_RESTART: begin
               fill_in = '0;
               seen_in = '0;
            end
            default: begin
            end
         endcase
      end

      if (result_take) begin
         busy_in = 1'b0;
         if (fwd_hit || rev_hit) begin
            rsp_valid_in = 1'b1;
            rsp_start_in = pos_ff;
            rsp_fhit_in  = fwd_hit;
            rsp_rhit_in  = rev_hit;
            rsp_fcnt_in  = (32'(fcnt[0]) > 32'(COUNT_MAX)) ? COUNT_MAX : MATCH_W'(fcnt[0]);
            rsp_rcnt_in  = (32'(rcnt[0]) > 32'(COUNT_MAX)) ? COUNT_MAX : MATCH_W'(rcnt[0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_length_ff <= CFG_W'(1);
         min_matches_ff <= '0;
         frame_len_ff   <= CNT_W'(1);
         fill_ff        <= '0;
         seen_ff        <= '0;
         busy_ff        <= 1'b0;
         start_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         read_length_ff <= read_length_in;
         min_matches_ff <= min_matches_in;
         frame_len_ff   <= frame_len_in;
         fill_ff        <= fill_in;
         seen_ff        <= seen_in;
         busy_ff        <= busy_in;
         start_ff       <= start_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      pos_ff       <= pos_in;
      rsp_start_ff <= rsp_start_in;
      rsp_fhit_ff  <= rsp_fhit_in;
      rsp_rhit_ff  <= rsp_rhit_in;
      rsp_fcnt_ff  <= rsp_fcnt_in;
      rsp_rcnt_ff  <= rsp_rcnt_in;
   end

   // the ring: cell k takes its window byte from cell k+1, the last cell from cell 0;
   // tokens walk from higher cells toward cell 0
   for (genvar k = 0; k < MAX_READ_LEN; k++) begin : g_cell
      localparam int UP = (k + 1) % MAX_READ_LEN;

      if (k == MAX_READ_LEN - 1) begin : g_end
         assign up_tok_v[k] = 1'b0;
         assign up_fcnt[k]  = '0;
         assign up_rcnt[k]  = '0;
      end else begin : g_mid
         assign up_tok_v[k] = tok_v[k + 1];
         assign up_fcnt[k]  = fcnt[k + 1];
         assign up_rcnt[k]  = rcnt[k + 1];
      end

      hwms_cell #(
         .MAX_READ_LEN (MAX_READ_LEN),
         .CELL_INDEX   (k)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl          (cell_ctl),
         .frame_len    (frame_len_ff),
         .base         (req_base),
         .load_index   (req_pattern_index),
         .up_window    (win[UP]),
         .up_tok_valid (up_tok_v[k]),
         .up_fwd_count (up_fcnt[k]),
         .up_rev_count (up_rcnt[k]),
         .window       (win[k]),
         .tok_valid    (tok_v[k]),
         .fwd_count    (fcnt[k]),
         .rev_count    (rcnt[k])
      );
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_window_start    = rsp_start_ff;
   assign rsp_forward_hit     = rsp_fhit_ff;
   assign rsp_reverse_hit     = rsp_rhit_ff;
   assign rsp_forward_matches = rsp_fcnt_ff;
   assign rsp_reverse_matches = rsp_rcnt_ff;

endmodule

// ===== design/hwms_checker.sv =====
// port-level checks of the hamming window match scanner and their bind to the top level
// depends on hwms_pkg and hamming_window_match_scan_top
module hwms_props (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [hwms_pkg::POS_W-1:0]      rsp_window_start,
   input logic                            rsp_forward_hit,
   input logic                            rsp_reverse_hit,
   input logic [hwms_pkg::MATCH_W-1:0]    rsp_forward_matches,
   input logic [hwms_pkg::MATCH_W-1:0]    rsp_reverse_matches,
   input logic                            csr_write_enable,
   input logic                            csr_index,
   input logic [hwms_pkg::CFG_W-1:0]      csr_write_data
);
   import hwms_pkg::*;

   // shadow of the threshold as written through the port
   logic [CFG_W-1:0] min_shadow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_shadow_ff <= '0;
      end else if (csr_write_enable && (csr_index == CSR_MIN_MATCHES)) begin
         min_shadow_ff <= csr_write_data;
      end
   end

   // a stalled item holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_window_start)
         && $stable(rsp_forward_matches) && $stable(rsp_reverse_matches))
      else $error("response payload changed while stalled");

   // a result comes only out of a scan, during which requests are refused
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared while requests were being taken");

   // hit flags agree with the counts and the written threshold
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_forward_hit == (rsp_forward_matches >= min_shadow_ff)))
      else $error("forward hit flag disagrees with forward count");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_reverse_hit == (rsp_reverse_matches >= min_shadow_ff))
         && (rsp_forward_hit || rsp_reverse_hit))
      else $error("reverse hit flag wrong or result without any hit");

endmodule

bind hamming_window_match_scan_top hwms_props u_hwms_props (.*);
